// File: sv/encoder_position_period_speed_core_assert.svh
// Assertion macros for the encoder tracker RTL.
`ifndef ENCODER_POSITION_PERIOD_SPEED_CORE_ASSERT_SVH
`define ENCODER_POSITION_PERIOD_SPEED_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("encoder tracker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EPPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("encoder tracker: next-cycle check failed");

`endif

// File: sv/epps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epps_pkg: shared types and constants of the encoder tracker
// Request codes, counter geometry, divider constants and the job record that
// travels from the front end through the queue to the speed back end.
// ----------------------------------------------------------------------------
package epps_pkg;

	// Counter geometry.
	localparam int COUNT_WIDTH    = 24;
	localparam int POSITION_SHIFT = 3;

	// Field widths.
	localparam int FIELD_W  = 16;
	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 48;

	// Period limit and speed numerator.
	localparam logic [FIELD_W-1:0] PERIOD_LIMIT = 16'h7FFF;
	localparam int QUOTIENT_BITS = 15;
	localparam int STEP_W        = $clog2(QUOTIENT_BITS);
	localparam logic [QUOTIENT_BITS-1:0] SPEED_NUMERATOR = 15'd32766;

	// Queue between the front end and the back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request kinds carried on the slave tuser.
	typedef enum logic [S_USER_W-1:0] {
		REQ_EDGE = 2'd0,
		REQ_STOP = 2'd1,
		REQ_LOAD = 2'd2
	} req_t;

	// Snapshot of the tracker state after one request.
	typedef struct packed {
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] period;
		logic               direction;
		logic               saturate;
	} job_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// File: sv/encoder_position_period_speed_core.sv
`timescale 1ns / 1ps
// A wheel encoder tracker: each request is a capture edge, a stop event or a
// position load, and each one yields exactly one result with the position,
// the signed period and the signed speed (32766 divided by the period). An
// edge request with a valid, nonzero period passes through the back end in
// order: the job is popped, the restoring divider runs fifteen steps of one
// quotient bit per cycle and the result is presented; stopped, out-of-range
// or zero-period requests skip the divider and go straight to the result. The
// front end updates the tracker state in the cycle it takes a request and a
// two-entry queue holds snapshots, so up to two requests are taken while the
// divider is busy or the output is stalled.
// ----------------------------------------------------------------------------
// encoder_position_period_speed_core: encoder position, period and speed
// Top level joining the request front end, the job queue and the divider
// back end on stream-style ports.
// ----------------------------------------------------------------------------
module encoder_position_period_speed_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] captured_period, [16] direction, [32:17] load_value, [39:33] zero
	input  logic [epps_pkg::S_DATA_W-1:0]   s_tdata,
	// [1:0] req_type
	input  logic [epps_pkg::S_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] position, [31:16] signed_period, [47:32] speed
	output logic [epps_pkg::M_DATA_W-1:0]   m_tdata
);
	import epps_pkg::*;

	`include "encoder_position_period_speed_core_assert.svh"

	logic        push;
	logic        pop;
	job_t        push_job;
	job_t        pop_job;
	queue_stat_t q_stat;

	// Request decode and tracker state.
	epps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_job (push_job),
		.q_stat   (q_stat)
	);

	// Snapshot queue.
	epps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (q_stat)
	);

	// Divider and result register.
	epps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Queue never overflows or underflows.
	`EPPS_ASSERT_SAME(a_no_push_full, clk, arst_n, push, !q_stat.full)
	`EPPS_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty)
	// A popped job leaves the queue no longer full in the next cycle.
	`EPPS_ASSERT_NEXT(a_pop_frees, clk, arst_n, pop && !push, !q_stat.full)
	// A saturated or zero period always comes with zero speed.
	`EPPS_ASSERT_SAME(a_sat_speed, clk, arst_n,
		m_tvalid && (m_tdata[31:16] == PERIOD_LIMIT || m_tdata[31:16] == 16'd0),
		m_tdata[47:32] == 16'd0)

endmodule

// File: sv/epps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epps_queue: job queue between front end and back end
// A small register FIFO that lets the front end keep accepting requests
// while the back end is busy dividing or waiting on its output.
// ----------------------------------------------------------------------------
module epps_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  epps_pkg::job_t       push_job,
	input  logic                 pop,
	output epps_pkg::job_t       pop_job,
	output epps_pkg::queue_stat_t stat
);
	import epps_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Status and head of the queue.
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_job    = slot_q[rd_ptr_q];

	// Storage for queued jobs.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count; the depth is a power of two so pointers wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: sv/epps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epps_front: request decode and tracker state
// Accepts requests, updates the edge counter, period, direction and flags,
// and pushes a snapshot of the new state into the job queue.
// ----------------------------------------------------------------------------
module epps_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [epps_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [epps_pkg::S_USER_W-1:0]   s_tuser,
	output logic                            push,
	output epps_pkg::job_t                  push_job,
	input  epps_pkg::queue_stat_t           q_stat
);
	import epps_pkg::*;

	logic                   edge_seen_q;
	logic                   stopped_q;
	logic                   dir_q;
	logic [FIELD_W-1:0]     period_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   edge_seen_d;
	logic                   stopped_d;
	logic                   dir_d;
	logic [FIELD_W-1:0]     period_d;
	logic [COUNT_WIDTH-1:0] count_d;

	req_t                           req;
	logic [FIELD_W-1:0]             cap_period;
	logic                           cap_dir;
	logic [FIELD_W-1:0]             load_value;
	logic [COUNT_WIDTH+FIELD_W-1:0] count_ext;

	// Field unpacking.
	assign req        = req_t'(s_tuser);
	assign cap_period = s_tdata[FIELD_W-1:0];
	assign cap_dir    = s_tdata[FIELD_W];
	assign load_value = s_tdata[2*FIELD_W:FIELD_W+1];

	// A request is taken whenever the queue has room.
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// Next tracker state for the request on the port.
	always_comb begin
		edge_seen_d = edge_seen_q;
		stopped_d   = stopped_q;
		dir_d       = dir_q;
		period_d    = period_q;
		count_d     = count_q;
		unique case (req)
			REQ_EDGE: begin
				dir_d = cap_dir;
				if (edge_seen_q) begin
					stopped_d = 1'b0;
					period_d  = cap_period;
					count_d   = cap_dir ? count_q + COUNT_WIDTH'(1)
					                    : count_q - COUNT_WIDTH'(1);
				end else begin
					edge_seen_d = 1'b1;
				end
			end
			REQ_STOP: begin
				stopped_d = 1'b1;
			end
			REQ_LOAD: begin
				count_d = {{(COUNT_WIDTH-FIELD_W){load_value[FIELD_W-1]}}, load_value}
				          << POSITION_SHIFT;
			end
			default: begin
				// Unused code: state is left alone, a result is still reported.
			end
		endcase
	end

	// Snapshot for the back end.
	assign count_ext         = {{FIELD_W{count_d[COUNT_WIDTH-1]}}, count_d};
	assign push_job.position = count_ext[POSITION_SHIFT +: FIELD_W];
	assign push_job.period   = period_d;
	assign push_job.direction = dir_d;
	assign push_job.saturate = stopped_d || (period_d > PERIOD_LIMIT);

	// Tracker state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_seen_q <= 1'b0;
			stopped_q   <= 1'b0;
			dir_q       <= 1'b0;
			period_q    <= '0;
			count_q     <= '0;
		end else if (push) begin
			edge_seen_q <= edge_seen_d;
			stopped_q   <= stopped_d;
			dir_q       <= dir_d;
			period_q    <= period_d;
			count_q     <= count_d;
		end
	end

endmodule

// File: sv/epps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epps_back: period and speed back end
// Pops jobs, divides the speed numerator by the period one quotient bit per
// cycle, applies the direction sign and holds the result for the master side.
// ----------------------------------------------------------------------------
module epps_back (
	input  logic                            clk,
	input  logic                            arst_n,
	output logic                            pop,
	input  epps_pkg::job_t                  pop_job,
	input  epps_pkg::queue_stat_t           q_stat,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [epps_pkg::M_DATA_W-1:0]   m_tdata
);
	import epps_pkg::*;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_DIV  = 3'b010,
		BK_OUT  = 3'b100
	} back_state_t;

	back_state_t              state_q;
	logic [STEP_W-1:0]        step_q;
	logic [QUOTIENT_BITS-1:0] divisor_q;
	logic [FIELD_W-1:0]       rem_q;
	logic [QUOTIENT_BITS-1:0] quo_q;
	logic                     dir_q;
	logic [FIELD_W-1:0]       pos_q;
	logic [M_DATA_W-1:0]      m_tdata_q;

	logic [FIELD_W-1:0]       rem_shift;
	logic                     fits;
	logic [FIELD_W-1:0]       rem_next;
	logic [QUOTIENT_BITS-1:0] quo_next;
	logic [FIELD_W-1:0]       quo_ext;
	logic [FIELD_W-1:0]       div_ext;
	logic [FIELD_W-1:0]       speed_out;
	logic [FIELD_W-1:0]       period_out;

	assign pop      = (state_q == BK_IDLE) && !q_stat.empty;
	assign m_tvalid = (state_q == BK_OUT);
	assign m_tdata  = m_tdata_q;

	// One restoring division step.
	assign rem_shift = {rem_q[FIELD_W-2:0], quo_q[QUOTIENT_BITS-1]};
	assign fits      = (rem_shift >= div_ext);
	assign rem_next  = fits ? rem_shift - div_ext : rem_shift;
	assign quo_next  = {quo_q[QUOTIENT_BITS-2:0], fits};

	// Direction sign on the final quotient and the period.
	assign div_ext    = {{(FIELD_W-QUOTIENT_BITS){1'b0}}, divisor_q};
	assign quo_ext    = {{(FIELD_W-QUOTIENT_BITS){1'b0}}, quo_next};
	assign speed_out  = dir_q ? quo_ext : ~quo_ext + FIELD_W'(1);
	assign period_out = dir_q ? div_ext : ~div_ext + FIELD_W'(1);

	// Divider datapath and result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					divisor_q <= pop_job.period[QUOTIENT_BITS-1:0];
					dir_q     <= pop_job.direction;
					pos_q     <= pop_job.position;
					rem_q     <= '0;
					quo_q     <= SPEED_NUMERATOR;
					if (pop_job.saturate) begin
						m_tdata_q <= {FIELD_W'(0), PERIOD_LIMIT, pop_job.position};
					end else if (pop_job.period == '0) begin
						m_tdata_q <= {FIELD_W'(0), FIELD_W'(0), pop_job.position};
					end
				end
			end
			BK_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (step_q == '0) begin
					m_tdata_q <= {speed_out, period_out, pos_q};
				end
			end
			BK_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (pop) begin
						step_q <= STEP_W'(QUOTIENT_BITS - 1);
						if (pop_job.saturate || pop_job.period == '0) begin
							state_q <= BK_OUT;
						end else begin
							state_q <= BK_DIV;
						end
					end
				end
				BK_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= BK_OUT;
					end
				end
				BK_OUT: begin
					if (m_tready) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

endmodule
